// ----- sv/deq_pkg.sv -----
// Shared types and codes for the double-ended queue unit.
package deq_pkg;

	// Operation codes carried by a request transaction
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	// Completion status reported with every result
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned OCC_BITS   = 5;

	// Request payload
	typedef struct packed {
		op_t                           op;
		logic signed [VALUE_BITS-1:0]  value_in;
	} req_t;

	// Result payload
	typedef struct packed {
		logic signed [VALUE_BITS-1:0]  front_value;
		logic signed [VALUE_BITS-1:0]  rear_value;
		logic                          is_empty;
		logic [OCC_BITS-1:0]           occupancy;
		status_t                       status;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- sv/double_ended_queue_unit.sv -----
// Double-ended queue unit: bounded ring-buffer deque with one result per transaction.
// After a request is accepted, the sequencer steps through execute, slot-memory read and
//   result load around the single-write, registered-read memory; the load waits while the
//   result register is stalled. No new request is taken until the sequencer is back in idle.
// A new request may be accepted while the previous result still waits to be taken.
// Reset clears pointers, count and valids; slot memory is not cleared.
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  req_t cmd_data,
	output logic res_valid,
	input  logic res_stall,
	output res_t res_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Sequencer
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and result path
	deq_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ----- sv/deq_ctrl.sv -----
// Sequencer for the double-ended queue: capture, execute, read, load result.
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;

	// Only the idle state takes a new transaction
	assign cmd_stall = (state_q != S_IDLE);

	// Commands decoded from state
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && cmd_valid;
		cmd.exec    = (state_q == S_EXEC);
		cmd.load    = (state_q == S_LOAD) && sts.out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_READ;
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A load always returns the sequencer to idle
	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_IDLE))
		else $error("load did not return to idle");

	// A capture is always followed by an execute cycle
	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("capture not followed by execute");

	// Execute is followed by the read cycle, never by another execute
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == S_READ))
		else $error("execute not followed by read");

endmodule

// ----- sv/deq_datapath.sv -----
// Datapath of the double-ended queue: pointers, count, slot memory, result register.
module deq_datapath
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     cmd_data,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     res_valid,
	input  logic     res_stall,
	output res_t     res_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	// Captured transaction
	op_t                  op_q;
	logic [WORD_BITS-1:0] value_q;

	// Queue state
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	status_t       status_q;

	// Slot memory and its registered read ports
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_front_q, rd_rear_q;

	// Result register
	res_t res_q;
	logic res_valid_q;

	// Next-state signals
	logic [AW-1:0] head_d, tail_d, wr_addr;
	logic [CW-1:0] count_d;
	logic          wr_en;
	status_t       status_d;
	logic          is_full, is_none;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign is_full = (count_q == CW'(DEPTH));
	assign is_none = (count_q == '0);

	// Operation decode and pointer update
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		status_d = ST_DONE;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					head_d  = wrap_dec(head_q);
					wr_en   = 1'b1;
					wr_addr = wrap_dec(head_q);
					count_d = count_q + 1'b1;
				end
			end
			OP_PUSH_REAR: begin
				if (is_full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					tail_d  = wrap_inc(tail_q);
					wr_en   = 1'b1;
					wr_addr = tail_q;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_none) begin
					status_d = ST_POP_EMPTY;
				end else begin
					head_d  = wrap_inc(head_q);
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_REAR: begin
				if (is_none) begin
					status_d = ST_POP_EMPTY;
				end else begin
					tail_d  = wrap_dec(tail_q);
					count_d = count_q - 1'b1;
				end
			end
			default: status_d = ST_DONE;
		endcase
	end

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= cmd_data.op;
			value_q <= WORD_BITS'(cmd_data.value_in);
		end
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) status_q <= status_d;
	end

	// Slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) mem[wr_addr] <= value_q;
		rd_front_q <= mem[head_q];
		rd_rear_q  <= mem[wrap_dec(tail_q)];
	end

	// Result register, free when empty or being taken this cycle
	assign sts.out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.front_value <= is_none ? '1 : VALUE_BITS'(rd_front_q);
			res_q.rear_value  <= is_none ? '1 : VALUE_BITS'(rd_rear_q);
			res_q.is_empty    <= is_none;
			res_q.occupancy   <= OCC_BITS'(count_q);
			res_q.status      <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Count never leaves its range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	// A refused operation leaves the queue state untouched
	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && status_d != ST_DONE) |=>
		($stable(count_q) && $stable(head_q) && $stable(tail_q)))
		else $error("refused operation changed state");

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!res_valid_q || !res_stall))
		else $error("result overwritten while stalled");

endmodule

// ----- dv/deq_checker.sv -----
// Channel monitor, ring-buffer deque predictor and result comparison for the deque unit.
module deq_checker
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  req_t cmd_data,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res_data,
	output int   errors,
	output int   outstanding,
	output int   ops_seen,
	output int   results_checked,
	output int   pops_refused,
	output int   pushes_refused,
	output int   full_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned IDX_BITS = $clog2(DEPTH);

	// Predicted deque contents and pointers
	logic [VALUE_BITS-1:0] ring [DEPTH];
	logic [IDX_BITS-1:0]   front_idx;
	logic [IDX_BITS-1:0]   back_idx;
	int unsigned           fill;

	// Results owed by the block, oldest first
	res_t owed_results[$];

	// Apply one operation to the predicted deque and return the result it yields
	function automatic res_t deque_apply(req_t r);
		res_t                o;
		status_t             st;
		logic [IDX_BITS-1:0] last;
		st = ST_DONE;
		case (r.op) inside
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (fill == DEPTH) begin
					st = ST_PUSH_FULL;
				end else if (r.op == OP_PUSH_FRONT) begin
					front_idx = front_idx - 1'b1;
					ring[front_idx] = r.value_in;
					fill++;
				end else begin
					ring[back_idx] = r.value_in;
					back_idx = back_idx + 1'b1;
					fill++;
				end
			end
			default: begin
				if (fill == 0) begin
					st = ST_POP_EMPTY;
				end else if (r.op == OP_POP_FRONT) begin
					front_idx = front_idx + 1'b1;
					fill--;
				end else begin
					back_idx = back_idx - 1'b1;
					fill--;
				end
			end
		endcase
		// An empty deque reports all ones at both ends
		last = back_idx - 1'b1;
		if (fill == 0) begin
			o.front_value = '1;
			o.rear_value  = '1;
		end else begin
			o.front_value = ring[front_idx];
			o.rear_value  = ring[last];
		end
		o.is_empty  = (fill == 0);
		o.occupancy = OCC_BITS'(fill);
		o.status    = st;
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] result %0d: %s", $time, results_checked, msg);
		errors++;
	endtask

	task automatic compare_result(res_t got, res_t want);
		if (got.front_value !== want.front_value)
			report_mismatch($sformatf("front_value %h, expected %h",
				got.front_value, want.front_value));
		if (got.rear_value !== want.rear_value)
			report_mismatch($sformatf("rear_value %h, expected %h",
				got.rear_value, want.rear_value));
		if (got.is_empty !== want.is_empty)
			report_mismatch($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
		if (got.occupancy !== want.occupancy)
			report_mismatch($sformatf("occupancy %0d, expected %0d",
				got.occupancy, want.occupancy));
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
	endtask

	// Watch both channels; results are taken before new operations at the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			front_idx       = '0;
			back_idx        = '0;
			fill            = 0;
			owed_results.delete();
			errors          = 0;
			outstanding     = 0;
			ops_seen        = 0;
			results_checked = 0;
			pops_refused    = 0;
			pushes_refused  = 0;
			full_hits       = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result with no operation waiting");
				end else begin
					want = owed_results.pop_front();
					compare_result(res_data, want);
				end
				results_checked++;
			end
			if (cmd_valid && !cmd_stall) begin
				want = deque_apply(cmd_data);
				owed_results.push_back(want);
				ops_seen++;
				case (want.status)
					ST_POP_EMPTY: pops_refused++;
					ST_PUSH_FULL: pushes_refused++;
					default: ;
				endcase
				if (want.status == ST_DONE && want.occupancy == DEPTH)
					full_hits++;
			end
			outstanding = owed_results.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the deque unit testbench: clock, reset, operation stimulus, result stalls, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int RANDOM_OPS   = 400;
	localparam int HOLD_AFTER   = 120;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	req_t cmd_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	int errors;
	int outstanding;
	int ops_seen;
	int results_checked;
	int pops_refused;
	int pushes_refused;
	int full_hits;

	int ops_sent  = 0;
	int cycles    = 0;
	bit quiet     = 1'b0;
	bit hold_done = 1'b0;

	// Words that hit the sign and magnitude corners
	logic [31:0] corner_words [8] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	double_ended_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	deq_checker deq_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.cmd_data        (cmd_data),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_data        (res_data),
		.errors          (errors),
		.outstanding     (outstanding),
		.ops_seen        (ops_seen),
		.results_checked (results_checked),
		.pops_refused    (pops_refused),
		.pushes_refused  (pushes_refused),
		.full_hits       (full_hits)
	);

	// Mostly short gaps, now and then a long one; never zero
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] pick_word();
		if ($urandom_range(0, 7) == 0)
			return corner_words[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Drop valid for a number of cycles
	task automatic idle(int gap);
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Offer one operation, wait for the transaction, then maybe pause
	task automatic issue(op_t op, logic [31:0] word);
		int gap;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_data  <= '{op: op, value_in: word};
		do @(posedge clk); while (cmd_stall);
		ops_sent++;
		gap = 0;
		if (!quiet && $urandom_range(0, 2) == 0)
			gap = pick_gap();
		idle(gap);
	endtask

	// Cycle budget
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
			$display("double_ended_queue_unit: mismatch");
			$finish;
		end
	end

	// Result side: random stalls plus one long hold-off that backs up the block
	initial begin : receiver
		int len;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && ops_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b1;
				len = pick_gap();
				repeat (len) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Operation stimulus and verdict
	initial begin : stimulus
		int   i;
		int   k;
		int   block_len;
		int   push_pct;
		int   rand_done;
		op_t  op;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_data  = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Pops on an empty deque
		issue(OP_POP_FRONT, pick_word());
		issue(OP_POP_REAR, pick_word());
		// Fill from both ends, first with the corner words and then with random words; the first front push wraps the head
		for (i = 0; i < 16; i++)
			issue((i % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, (i < 8) ? corner_words[i] : $urandom);
		// Pushes on a full deque are refused; then one pop from each end
		issue(OP_PUSH_FRONT, pick_word());
		issue(OP_PUSH_REAR, pick_word());
		issue(OP_POP_FRONT, pick_word());
		issue(OP_POP_REAR, pick_word());

		// Random blocks that lean toward filling, churning or draining
		rand_done = 0;
		while (rand_done < RANDOM_OPS) begin
			block_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 50;
				default: push_pct = 15;
			endcase
			quiet = ($urandom_range(0, 4) == 0);
			for (k = 0; k < block_len && rand_done < RANDOM_OPS; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
				else
					op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
				issue(op, pick_word());
				rand_done++;
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d operations and %0d results in %0d cycles",
			ops_seen, results_checked, cycles);
		$display("refused pops %0d, refused pushes %0d, times the deque filled %0d",
			pops_refused, pushes_refused, full_hits);
		if (errors == 0 && outstanding == 0) begin
			$display("double_ended_queue_unit: match");
		end else begin
			$display("double_ended_queue_unit: mismatch");
		end
		$finish;
	end

endmodule
